### src/bmdt_pkg.sv
package bmdt_pkg;

  // Default block length and the sample width carried on the input stream
  localparam int BLOCK_LEN_DEF = 64;
  localparam int SAMPLE_BITS   = 16;

  // Block sums, deviations and trigger level share one fixed width
  localparam int SUM_W = 22;
  localparam int DEV_W = 22;

  localparam logic [DEV_W-1:0]  DEV_MAX = {DEV_W{1'b1}};
  localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W+1)'(1 << (SUM_W - 1));

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 120;

  // Input action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [DEV_W-1:0]              dev_t;

  // One input item as seen by the core
  typedef struct packed {
    logic    action;
    sample_t sample_x;
    sample_t sample_y;
    sample_t sample_z;
  } item_t;

  // One result item
  typedef struct packed {
    logic triggered;
    logic checked;
    dev_t deviation;
    dev_t last_block_peak;
    logic mean_valid;
    sum_t mean_x;
    sum_t mean_y;
    sum_t mean_z;
  } result_t;

endpackage

### src/bmdt_axis_dev.sv
module bmdt_axis_dev #(
  parameter int BLOCK_LEN = bmdt_pkg::BLOCK_LEN_DEF
) (
  input  bmdt_pkg::sample_t sample,
  input  bmdt_pkg::sum_t    ref_sum,
  output bmdt_pkg::dev_t    dev
);

  // Wide enough for sample * BLOCK_LEN against a block sum, plus sign
  localparam int PROD_W = bmdt_pkg::SAMPLE_BITS + $clog2(BLOCK_LEN) + 1;
  localparam int D_W    = ((PROD_W > bmdt_pkg::SUM_W) ? PROD_W : bmdt_pkg::SUM_W) + 1;
  localparam logic signed [D_W-1:0] SCALE = D_W'(BLOCK_LEN);

  logic signed [D_W-1:0] scaled;
  logic signed [D_W-1:0] diff;
  logic [D_W-1:0]        mag;

  // Scale the sample, take the distance from the mean, clamp to the deviation range
  always_comb begin
    scaled = D_W'(sample) * SCALE;
    diff   = scaled - D_W'(ref_sum);
    mag    = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
    if (mag > D_W'(bmdt_pkg::DEV_MAX)) begin
      dev = bmdt_pkg::DEV_MAX;
    end else begin
      dev = mag[bmdt_pkg::DEV_W-1:0];
    end
  end

endmodule

### src/bmdt_core.sv
module bmdt_core #(
  parameter int BLOCK_LEN = bmdt_pkg::BLOCK_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  bmdt_pkg::dev_t        cfg_wr_data,
  input  logic                  step,
  input  bmdt_pkg::item_t       item,
  output bmdt_pkg::result_t     result
);

  localparam int FILL_W = $clog2(BLOCK_LEN + 1);
  localparam logic [FILL_W-1:0] FILL_WRAP = FILL_W'(BLOCK_LEN);

  logic [FILL_W-1:0]   fill_r, fill_nxt;
  bmdt_pkg::sum_t      run_r [3];
  bmdt_pkg::sum_t      run_nxt [3];
  bmdt_pkg::sum_t      ref_r [3];
  bmdt_pkg::sum_t      ref_nxt [3];
  logic                mean_ready_r, mean_ready_nxt;
  bmdt_pkg::dev_t      peak_r, peak_nxt;
  bmdt_pkg::dev_t      latched_r, latched_nxt;
  logic                sticky_r, sticky_nxt;
  bmdt_pkg::dev_t      level_r;

  bmdt_pkg::sample_t   smp [3];
  bmdt_pkg::dev_t      axis_dev [3];
  bmdt_pkg::dev_t      dev_max;
  logic                wrap;
  logic                check;
  logic                trig_out;
  logic [FILL_W-1:0]   fill_base;
  bmdt_pkg::sum_t      run_base [3];
  logic signed [bmdt_pkg::SUM_W:0] acc [3];

  assign smp[0] = item.sample_x;
  assign smp[1] = item.sample_y;
  assign smp[2] = item.sample_z;

  // Per-axis deviation from the reference mean
  for (genvar a = 0; a < 3; a++) begin : g_axis
    bmdt_axis_dev #(
      .BLOCK_LEN (BLOCK_LEN)
    ) u_axis_dev (
      .sample  (smp[a]),
      .ref_sum (ref_r[a]),
      .dev     (axis_dev[a])
    );
  end

  // Largest axis deviation
  always_comb begin
    dev_max = axis_dev[0];
    if (axis_dev[1] > dev_max) dev_max = axis_dev[1];
    if (axis_dev[2] > dev_max) dev_max = axis_dev[2];
  end

  // Next state and result for the item in the input register
  always_comb begin
    fill_nxt       = fill_r;
    mean_ready_nxt = mean_ready_r;
    peak_nxt       = peak_r;
    latched_nxt    = latched_r;
    sticky_nxt     = sticky_r;
    wrap           = (fill_r == FILL_WRAP);
    check          = 1'b0;
    trig_out       = sticky_r;
    fill_base      = fill_r;
    for (int i = 0; i < 3; i++) begin
      run_nxt[i]  = run_r[i];
      ref_nxt[i]  = ref_r[i];
      run_base[i] = run_r[i];
      acc[i]      = '0;
    end

    if (item.action == bmdt_pkg::ACT_POLL) begin
      // Report the sticky flag, then clear it
      trig_out   = sticky_r;
      sticky_nxt = 1'b0;
    end else begin
      if (!wrap) begin
        if (mean_ready_r) begin
          check = 1'b1;
          if (dev_max > level_r) sticky_nxt = 1'b1;
          if (dev_max > peak_r) peak_nxt = dev_max;
        end
      end else begin
        // Close the block: sums become the mean, peak is latched
        fill_base = '0;
        for (int i = 0; i < 3; i++) begin
          ref_nxt[i]  = run_r[i];
          run_base[i] = '0;
        end
        latched_nxt    = peak_r;
        mean_ready_nxt = 1'b1;
        peak_nxt       = '0;
      end

      // Accumulate with saturation
      for (int i = 0; i < 3; i++) begin
        acc[i] = (bmdt_pkg::SUM_W+1)'(run_base[i]) + (bmdt_pkg::SUM_W+1)'(smp[i]);
        if (acc[i] > bmdt_pkg::SUM_MAX) begin
          run_nxt[i] = bmdt_pkg::SUM_W'(bmdt_pkg::SUM_MAX);
        end else if (acc[i] < bmdt_pkg::SUM_MIN) begin
          run_nxt[i] = bmdt_pkg::SUM_W'(bmdt_pkg::SUM_MIN);
        end else begin
          run_nxt[i] = acc[i][bmdt_pkg::SUM_W-1:0];
        end
      end
      fill_nxt = fill_base + FILL_W'(1);
      trig_out = sticky_nxt;
    end

    result.triggered       = trig_out;
    result.checked         = check;
    result.deviation       = check ? dev_max : '0;
    result.last_block_peak = latched_nxt;
    result.mean_valid      = mean_ready_nxt;
    result.mean_x          = ref_nxt[0];
    result.mean_y          = ref_nxt[1];
    result.mean_z          = ref_nxt[2];
  end

  // Trigger level register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= bmdt_pkg::DEV_MAX;
    end else if (cfg_wr_en) begin
      level_r <= cfg_wr_data;
    end
  end

  // Advance block state on each transfer through the core
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      mean_ready_r <= 1'b0;
      peak_r       <= '0;
      latched_r    <= '0;
      sticky_r     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        run_r[i] <= '0;
        ref_r[i] <= '0;
      end
    end else if (step) begin
      fill_r       <= fill_nxt;
      mean_ready_r <= mean_ready_nxt;
      peak_r       <= peak_nxt;
      latched_r    <= latched_nxt;
      sticky_r     <= sticky_nxt;
      for (int i = 0; i < 3; i++) begin
        run_r[i] <= run_nxt[i];
        ref_r[i] <= ref_nxt[i];
      end
    end
  end

endmodule

### src/block_mean_deviation_trigger_unit.sv
// Three-axis block mean deviation trigger. Samples (in_tuser = 0) are summed
// over blocks of BLOCK_LEN; the sample arriving after a full block closes it,
// its sums become the reference mean (kept as the exact block sum, so every
// deviation and the trigger level carry log2(BLOCK_LEN) fraction bits), and it
// starts the next block unchecked. Later samples are compared against the mean;
// a deviation strictly above the trigger level sets a sticky flag, which a poll
// (in_tuser = 1) reports and clears. Every transfer yields one result. The block
// takes one item per cycle while the result stream does not stall the result register:
// the work is one pass of adds, absolute differences and compares between the
// input register and the result register, and a result waits in the result
// register until the result stream takes it.
module block_mean_deviation_trigger_unit #(
  parameter int BLOCK_LEN = bmdt_pkg::BLOCK_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration: trigger_level
  input  logic                                cfg_wr_en,
  input  logic [bmdt_pkg::DEV_W-1:0]          cfg_wr_data,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] sample_x, [31:16] sample_y, [47:32] sample_z
  input  logic [bmdt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] action
  input  logic                                in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] triggered, [1] checked, [23:2] deviation, [45:24] last_block_peak,
  // [46] mean_valid, [68:47] mean_x, [90:69] mean_y, [112:91] mean_z, rest zero
  output logic [bmdt_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int SB = bmdt_pkg::SAMPLE_BITS;

  logic              in_v_r;
  bmdt_pkg::item_t   item_r;
  logic              out_v_r;
  bmdt_pkg::result_t res_r;
  bmdt_pkg::result_t res_nxt;
  logic              advance;
  logic              step;

  // Pipeline handshake
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || advance;
  assign step      = in_v_r && advance;

  bmdt_core #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (item_r),
    .result      (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action   <= in_tuser;
      item_r.sample_x <= in_tdata[SB-1:0];
      item_r.sample_y <= in_tdata[2*SB-1:SB];
      item_r.sample_z <= in_tdata[3*SB-1:2*SB];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  // Pack the result onto the output stream
  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, res_r.mean_z, res_r.mean_y, res_r.mean_x, res_r.mean_valid,
                       res_r.last_block_peak, res_r.deviation, res_r.checked,
                       res_r.triggered};

endmodule

### sim/tb_block_mean_deviation_trigger_unit.sv
module tb_block_mean_deviation_trigger_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bmdt_pkg::*;

  localparam int BLK          = BLOCK_LEN_DEF;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 265;
  localparam int HOLD_PHASE   = 3;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [DEV_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  block_mean_deviation_trigger_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus and predicted reports
  item_t   pending_samples[$];
  result_t deviation_reports[$];
  item_t   in_item = '0;

  // Handshake bookkeeping
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic rx_hold = 1'b0;
  int   feed_wait = 0;
  int   drain_wait = 0;
  int   feed_gap_max = 0;
  int   drain_gap_max = 0;
  int   phase_no = -1;
  int   fail_count = 0;
  int   cycle_count = 0;

  // Predictor state
  int       blk_fill;
  longint   blk_sum[3];
  longint   ref_sum[3];
  bit       ref_ready;
  dev_t     blk_peak;
  dev_t     held_peak;
  bit       trig_sticky;
  dev_t     trig_level;

  task automatic note_mismatch(input string what, input longint got, input longint want);
    if (fail_count < 40) begin
      $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  function automatic item_t pack_item(input logic act, input int x, input int y, input int z);
    item_t it;
    it.action   = act;
    it.sample_x = sample_t'(x);
    it.sample_y = sample_t'(y);
    it.sample_z = sample_t'(z);
    return it;
  endfunction

  // Advance the block mean model by one item and return the report it produces
  function automatic result_t step_deviation_model(input item_t it);
    result_t r;
    longint  s[3];
    longint  d;
    dev_t    worst;
    bit      seen;
    r     = '0;
    worst = '0;
    seen  = 1'b0;
    if (it.action == ACT_POLL) begin
      r.triggered = trig_sticky;
      trig_sticky = 1'b0;
    end else begin
      s[0] = it.sample_x;
      s[1] = it.sample_y;
      s[2] = it.sample_z;
      if (blk_fill < BLK) begin
        // Compare against the reference sums once a mean exists
        if (ref_ready) begin
          for (int a = 0; a < 3; a++) begin
            d = s[a] * BLK - ref_sum[a];
            if (d < 0) d = -d;
            if (d > longint'(DEV_MAX)) d = longint'(DEV_MAX);
            if (d > longint'(worst)) worst = dev_t'(d);
          end
          seen = 1'b1;
          if (worst > trig_level) trig_sticky = 1'b1;
          if (worst > blk_peak) blk_peak = worst;
        end
      end else begin
        // Close the block: sums become the mean, peak is latched
        blk_fill = 0;
        for (int a = 0; a < 3; a++) begin
          ref_sum[a] = blk_sum[a];
          blk_sum[a] = 0;
        end
        held_peak = blk_peak;
        ref_ready = 1'b1;
        blk_peak  = '0;
      end
      // Accumulate with saturation to the signed sum range
      for (int a = 0; a < 3; a++) begin
        d = blk_sum[a] + s[a];
        if (d > longint'(SUM_MAX)) d = longint'(SUM_MAX);
        if (d < longint'(SUM_MIN)) d = longint'(SUM_MIN);
        blk_sum[a] = d;
      end
      blk_fill++;
      r.triggered = trig_sticky;
    end
    r.checked         = seen;
    r.deviation       = worst;
    r.last_block_peak = held_peak;
    r.mean_valid      = ref_ready;
    r.mean_x          = sum_t'(ref_sum[0]);
    r.mean_y          = sum_t'(ref_sum[1]);
    r.mean_z          = sum_t'(ref_sum[2]);
    return r;
  endfunction

  // Feed pending samples onto the input stream
  always @(negedge clk) begin : sample_feed
    item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // hold the offered item until its transfer
    end else if (feed_wait > 0) begin
      feed_wait <= feed_wait - 1;
      in_tvalid <= 1'b0;
    end else if (pending_samples.size() != 0) begin
      nxt = pending_samples.pop_front();
      in_item   <= nxt;
      in_tdata  <= {nxt.sample_z, nxt.sample_y, nxt.sample_x};
      in_tuser  <= nxt.action;
      in_tvalid <= 1'b1;
      feed_wait <= $urandom_range(0, feed_gap_max);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Predict on every input transfer
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      deviation_reports.push_back(step_deviation_model(in_item));
    end
  end

  // Drive ready on the result stream with random stalls
  always @(negedge clk) begin : result_drain
    int w;
    w = drain_wait;
    if (out_fire) w = $urandom_range(0, drain_gap_max);
    if (!rst_n || rx_hold) begin
      out_tready <= 1'b0;
    end else if (w > 0) begin
      w = w - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
    drain_wait = w;
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    out_fire <= out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.triggered       = out_tdata[0];
      got.checked         = out_tdata[1];
      got.deviation       = out_tdata[23:2];
      got.last_block_peak = out_tdata[45:24];
      got.mean_valid      = out_tdata[46];
      got.mean_x          = out_tdata[68:47];
      got.mean_y          = out_tdata[90:69];
      got.mean_z          = out_tdata[112:91];
      if (deviation_reports.size() == 0) begin
        note_mismatch("result with no prediction waiting", 1, 0);
      end else begin
        want = deviation_reports.pop_front();
        if (got.triggered !== want.triggered)
          note_mismatch("triggered", got.triggered, want.triggered);
        if (got.checked !== want.checked)
          note_mismatch("checked", got.checked, want.checked);
        if (got.deviation !== want.deviation)
          note_mismatch("deviation", got.deviation, want.deviation);
        if (got.last_block_peak !== want.last_block_peak)
          note_mismatch("last_block_peak", got.last_block_peak, want.last_block_peak);
        if (got.mean_valid !== want.mean_valid)
          note_mismatch("mean_valid", got.mean_valid, want.mean_valid);
        if (got.mean_x !== want.mean_x)
          note_mismatch("mean_x", got.mean_x, want.mean_x);
        if (got.mean_y !== want.mean_y)
          note_mismatch("mean_y", got.mean_y, want.mean_y);
        if (got.mean_z !== want.mean_z)
          note_mismatch("mean_z", got.mean_z, want.mean_z);
      end
    end
  end

  // Hold off the receiver for a long stretch so the block backs up
  initial begin
    wait (phase_no == HOLD_PHASE);
    repeat (20) @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // Abort a run that reaches CYCLE_LIMIT
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("block_mean_deviation_trigger_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int     amp;
    int     sel;
    int     roll;
    int     v;
    int     base[3];
    int     smp[3];
    logic   act;
    dev_t   lvl;

    blk_fill    = 0;
    blk_sum     = '{0, 0, 0};
    ref_sum     = '{0, 0, 0};
    ref_ready   = 1'b0;
    blk_peak    = '0;
    held_peak   = '0;
    trig_sticky = 1'b0;
    trig_level  = DEV_MAX;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, polls, bit patterns, all under the reset level
    pending_samples.push_back(pack_item(ACT_POLL, 0, 0, 0));
    pending_samples.push_back(pack_item(ACT_ADD, 32767, 32767, 32767));
    pending_samples.push_back(pack_item(ACT_ADD, -32768, -32768, -32768));
    pending_samples.push_back(pack_item(ACT_ADD, 0, 0, 0));
    pending_samples.push_back(pack_item(ACT_ADD, -1, -1, -1));
    pending_samples.push_back(pack_item(ACT_ADD, 1, 1, 1));
    pending_samples.push_back(pack_item(ACT_ADD, 32767, -32768, 0));
    pending_samples.push_back(pack_item(ACT_ADD, -32768, 0, 32767));
    pending_samples.push_back(pack_item(ACT_ADD, 'h5555, 'hAAAA, 'h5555));
    pending_samples.push_back(pack_item(ACT_ADD, 'hAAAA, 'h5555, 'hAAAA));
    pending_samples.push_back(pack_item(ACT_POLL, -1, -1, -1));
    pending_samples.push_back(pack_item(ACT_POLL, 32767, -32768, 1));
    pending_samples.push_back(pack_item(ACT_ADD, 0, 32767, -32768));
    pending_samples.push_back(pack_item(ACT_POLL, 0, 0, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      // Wait for the block to go idle before touching the register
      while (pending_samples.size() != 0 || deviation_reports.size() != 0 || in_tvalid)
        @(negedge clk);
      repeat (4) @(negedge clk);

      case (ph)
        0: begin lvl = DEV_MAX; amp = 200; feed_gap_max = 0; drain_gap_max = 0; end
        1: begin lvl = '0; amp = 50; feed_gap_max = 6; drain_gap_max = 6; end
        2: begin lvl = dev_t'($urandom); amp = 2000; feed_gap_max = 3; drain_gap_max = 3; end
        3: begin lvl = dev_t'(64 * 300); amp = 400; feed_gap_max = 1; drain_gap_max = 6; end
        4: begin
          lvl = dev_t'($urandom_range(0, 64 * 100));
          amp = 100; feed_gap_max = 6; drain_gap_max = 0;
        end
        default: begin lvl = DEV_MAX - 64; amp = 0; feed_gap_max = 0; drain_gap_max = 6; end
      endcase

      // Write the trigger level for this phase
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= lvl;
      @(negedge clk);
      cfg_wr_en   <= 1'b0;
      trig_level  = lvl;
      @(posedge clk);
      phase_no = ph;

      // Mostly noisy samples around a base that is now and then redrawn, with polls and noise
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 0 || $urandom_range(0, 79) == 0) begin
          for (int a = 0; a < 3; a++) begin
            sel = $urandom_range(0, 3);
            base[a] = (sel == 0) ? -32768 : (sel == 1) ? 32767 :
                      int'($urandom_range(0, 65535)) - 32768;
          end
        end
        roll = $urandom_range(0, 99);
        act  = (roll < 10) ? ACT_POLL : ACT_ADD;
        for (int a = 0; a < 3; a++) begin
          if (roll < 16) begin
            smp[a] = int'($urandom_range(0, 65535)) - 32768;
          end else if (roll < 19) begin
            smp[a] = $urandom_range(0, 1) ? 32767 : -32768;
          end else begin
            v = base[a] + int'($urandom_range(0, 2 * amp)) - amp;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            smp[a] = v;
          end
        end
        pending_samples.push_back(pack_item(act, smp[0], smp[1], smp[2]));
      end
    end

    // Drain and settle
    while (pending_samples.size() != 0 || deviation_reports.size() != 0 || in_tvalid)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (deviation_reports.size() != 0)
      note_mismatch("predictions left unmatched", deviation_reports.size(), 0);

    if (fail_count == 0) begin
      $display("block_mean_deviation_trigger_unit: match");
    end else begin
      $display("block_mean_deviation_trigger_unit: mismatch");
    end
    $finish;
  end

endmodule
